// File: src/glyph_outline_lru_directory_defines.svh
// Assertion macros for the glyph outline LRU directory.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef GLYPH_OUTLINE_LRU_DIRECTORY_DEFINES_SVH
`define GLYPH_OUTLINE_LRU_DIRECTORY_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define GOLRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define GOLRD_ASSERT_NEVER(label, cond, msg) \
  `GOLRD_ASSERT(label, !(cond), msg)

`endif

// File: src/golrd_pkg.sv
// Shared types and constants of the glyph outline LRU directory.
// No dependencies; imported by golrd_engine and the top level.
`default_nettype none

package golrd_pkg;

  // Directory size and derived widths
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RANK_W   = IDX_W;

  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(CAPACITY - 1);

  // Field widths of the stream words
  localparam int FONT_W  = 32;
  localparam int GLYPH_W = 16;
  localparam int SLOT_W  = 8;
  localparam int REM_W   = 9;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_type_e;

  // One request word
  typedef struct packed {
    req_type_e            req_type;
    logic                 fetch_ok;
    logic [GLYPH_W-1:0]   glyph_index;
    logic [FONT_W-1:0]    font_id;
  } req_t;

  // One result word, last field in the lowest bits
  typedef struct packed {
    logic [REM_W-1:0]     removed_count;
    logic                 failed;
    logic [GLYPH_W-1:0]   evicted_glyph;
    logic [FONT_W-1:0]    evicted_font;
    logic                 evicted;
    logic                 stored;
    logic [SLOT_W-1:0]    slot;
    logic                 hit;
  } res_t;

  localparam int RES_W     = $bits(res_t);
  localparam int OUT_PAD_W = OUT_TDATA_W - RES_W;

  // One directory entry as held in the tag memory
  typedef struct packed {
    logic [FONT_W-1:0]    font;
    logic [GLYPH_W-1:0]   glyph;
    logic [RANK_W-1:0]    rank;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

endpackage

`default_nettype wire

// File: src/golrd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module golrd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/golrd_engine.sv
// Sweep engine of the glyph outline LRU directory: tag scan, rank update and flush repair.
// Depends on golrd_pkg, golrd_ram and the assertion macro header.
`default_nettype none
`include "glyph_outline_lru_directory_defines.svh"

module golrd_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  golrd_pkg::req_t req_i,
  output logic            req_ready_o,
  output logic            res_valid_o,
  output golrd_pkg::res_t res_o,
  input  logic            res_ready_i
);
  import golrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_PREFIX,
    ST_RENUM,
    ST_DONE
  } state_e;

  // Control state
  state_e              state_q;
  logic [CNT_W-1:0]    idx_q;
  logic                p_vld_q;
  logic                s2_vld_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CAPACITY-1:0] rmap_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    acc_q;
  logic                hit_q;
  logic                free_q;
  logic                store_q;

  // Payload state
  req_t                req_q;
  res_t                res_q;
  logic [IDX_W-1:0]    p_idx_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [RANK_W-1:0]   hit_rank_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [IDX_W-1:0]    lru_idx_q;
  logic [FONT_W-1:0]   lru_font_q;
  logic [GLYPH_W-1:0]  lru_glyph_q;
  logic [IDX_W-1:0]    tgt_idx_q;
  logic [IDX_W-1:0]    s2_idx_q;
  logic [FONT_W-1:0]   s2_font_q;
  logic [GLYPH_W-1:0]  s2_glyph_q;
  logic [RANK_W-1:0]   s2_rank_q;
  logic                s2_valid_q;

  // Memory ports
  logic                tag_we;
  logic [IDX_W-1:0]    tag_waddr;
  tag_t                tag_wdata;
  logic                tag_re;
  logic [IDX_W-1:0]    tag_raddr;
  tag_t                ent;
  logic                shift_we;
  logic [IDX_W-1:0]    shift_waddr;
  logic [CNT_W-1:0]    shift_wdata;
  logic                shift_re;
  logic [IDX_W-1:0]    shift_raddr;
  logic [CNT_W-1:0]    shift_rdata;

  // Decode helpers
  logic                sweep_run;
  logic                p_valid;
  logic                key_match;
  logic                font_match;
  logic                is_tgt;
  logic                full;
  logic                is_flush;
  res_t                res_d;
  logic [IDX_W-1:0]    tgt_d;

  golrd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (TAG_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (ent)
  );

  // Rank shift table, filled by the prefix pass of a flush
  golrd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CNT_W)
  ) u_shift_ram (
    .clk_i   (clk_i),
    .we_i    (shift_we),
    .waddr_i (shift_waddr),
    .wdata_i (shift_wdata),
    .re_i    (shift_re),
    .raddr_i (shift_raddr),
    .rdata_o (shift_rdata)
  );

  assign sweep_run  = (idx_q != CAP_CNT);
  assign p_valid    = valid_q[p_idx_q];
  assign font_match = p_valid && (ent.font == req_q.font_id);
  assign key_match  = font_match && (ent.glyph == req_q.glyph_index);
  assign is_tgt     = (p_idx_q == tgt_idx_q);
  assign full       = (count_q == CAP_CNT);
  assign is_flush   = (req_q.req_type == REQ_FLUSH);

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // Form the result and the slot to rewrite once the scan is through
  always_comb begin
    res_d = '0;
    tgt_d = hit_idx_q;
    if (is_flush) begin
      res_d.removed_count = REM_W'(rem_q);
    end else if (hit_q) begin
      res_d.hit  = 1'b1;
      res_d.slot = SLOT_W'(hit_idx_q);
    end else if (!req_q.fetch_ok) begin
      res_d.failed = 1'b1;
    end else begin
      tgt_d          = full ? lru_idx_q : free_idx_q;
      res_d.stored   = 1'b1;
      res_d.slot     = SLOT_W'(tgt_d);
      res_d.evicted  = full;
      if (full) begin
        res_d.evicted_font  = lru_font_q;
        res_d.evicted_glyph = lru_glyph_q;
      end
    end
  end

  // Drive the memory ports for the current pass
  always_comb begin
    tag_re      = 1'b0;
    tag_raddr   = idx_q[IDX_W-1:0];
    tag_we      = 1'b0;
    tag_waddr   = p_idx_q;
    tag_wdata   = '0;
    shift_we    = 1'b0;
    shift_waddr = idx_q[IDX_W-1:0];
    shift_wdata = acc_q;
    shift_re    = 1'b0;
    shift_raddr = ent.rank;
    unique case (state_q)
      ST_SCAN: begin
        tag_re = sweep_run;
      end
      ST_UPD: begin
        tag_re = sweep_run;
        tag_we = p_vld_q &&
                 (is_tgt || (p_valid && (store_q || (ent.rank < hit_rank_q))));
        if (is_tgt) begin
          tag_wdata = '{font: req_q.font_id, glyph: req_q.glyph_index, rank: '0};
        end else begin
          tag_wdata = '{font: ent.font, glyph: ent.glyph,
                        rank: ent.rank + RANK_W'(1)};
        end
      end
      ST_PREFIX: begin
        shift_we = sweep_run;
      end
      ST_RENUM: begin
        tag_re    = sweep_run;
        shift_re  = p_vld_q;
        tag_we    = s2_vld_q && s2_valid_q;
        tag_waddr = s2_idx_q;
        tag_wdata = '{font: s2_font_q, glyph: s2_glyph_q,
                      rank: s2_rank_q - shift_rdata[RANK_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Sequence the passes and hold the directory control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      p_vld_q  <= 1'b0;
      s2_vld_q <= 1'b0;
      valid_q  <= '0;
      rmap_q   <= '0;
      count_q  <= '0;
      rem_q    <= '0;
      acc_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      store_q  <= 1'b0;
    end else begin
      p_vld_q  <= tag_re;
      s2_vld_q <= (state_q == ST_RENUM) && p_vld_q;
      if (tag_re) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            state_q <= ST_SCAN;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            rem_q   <= '0;
            acc_q   <= '0;
          end
        end
        ST_SCAN: begin
          if (p_vld_q) begin
            if (is_flush) begin
              // Drop every entry of the named font and mark its rank
              if (font_match) begin
                valid_q[p_idx_q] <= 1'b0;
                rem_q            <= rem_q + CNT_W'(1);
                rmap_q[ent.rank] <= 1'b1;
              end
            end else begin
              if (key_match) begin
                hit_q <= 1'b1;
              end
              if (!p_valid) begin
                free_q <= 1'b1;
              end
            end
          end else if (!sweep_run) begin
            idx_q <= '0;
            if (is_flush) begin
              count_q <= count_q - rem_q;
              state_q <= (rem_q != '0) ? ST_PREFIX : ST_DONE;
            end else if (hit_q) begin
              store_q <= 1'b0;
              state_q <= ST_UPD;
            end else if (!req_q.fetch_ok) begin
              state_q <= ST_DONE;
            end else begin
              store_q <= 1'b1;
              if (!full) begin
                count_q <= count_q + CNT_W'(1);
              end
              state_q <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          if (p_vld_q && is_tgt && store_q) begin
            valid_q[tgt_idx_q] <= 1'b1;
          end
          if (!p_vld_q && !sweep_run) begin
            state_q <= ST_DONE;
          end
        end
        ST_PREFIX: begin
          // Count removed ranks below each rank, clearing the map behind
          if (sweep_run) begin
            acc_q                     <= acc_q + CNT_W'(rmap_q[idx_q[IDX_W-1:0]]);
            rmap_q[idx_q[IDX_W-1:0]]  <= 1'b0;
            idx_q                     <= idx_q + CNT_W'(1);
          end else begin
            idx_q   <= '0;
            state_q <= ST_RENUM;
          end
        end
        ST_RENUM: begin
          if (!sweep_run && !p_vld_q && !s2_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture request, scan findings and the renumber stage
  always_ff @(posedge clk_i) begin
    if (tag_re) begin
      p_idx_q <= tag_raddr;
    end
    if ((state_q == ST_IDLE) && req_valid_i) begin
      req_q <= req_i;
    end
    if ((state_q == ST_SCAN) && p_vld_q && !is_flush) begin
      if (key_match) begin
        hit_idx_q  <= p_idx_q;
        hit_rank_q <= ent.rank;
      end
      if (!p_valid && !free_q) begin
        free_idx_q <= p_idx_q;
      end
      if (p_valid && (ent.rank == LRU_RANK)) begin
        lru_idx_q   <= p_idx_q;
        lru_font_q  <= ent.font;
        lru_glyph_q <= ent.glyph;
      end
    end
    if ((state_q == ST_SCAN) && !p_vld_q && !sweep_run) begin
      res_q     <= res_d;
      tgt_idx_q <= tgt_d;
    end
    if ((state_q == ST_RENUM) && p_vld_q) begin
      s2_idx_q   <= p_idx_q;
      s2_font_q  <= ent.font;
      s2_glyph_q <= ent.glyph;
      s2_rank_q  <= ent.rank;
      s2_valid_q <= p_valid;
    end
  end

  `GOLRD_ASSERT(a_count_bound, count_q <= CAP_CNT, "entry count above capacity")
  `GOLRD_ASSERT(a_count_valid, (state_q == ST_IDLE) |-> ($countones(valid_q) == count_q),
                "entry count disagrees with valid bits")
  `GOLRD_ASSERT(a_rmap_clear, (state_q == ST_IDLE) |-> (rmap_q == '0),
                "removed-rank map not cleared after flush")
  `GOLRD_ASSERT_NEVER(a_res_excl, res_valid_o && res_q.hit && (res_q.stored || res_q.failed),
                      "hit result also marked stored or failed")

endmodule

`default_nettype wire

// File: src/glyph_outline_lru_directory.sv
// Top level of the glyph outline LRU directory: stream ports and the result word register.
// Depends on golrd_pkg and golrd_engine.
//
// Fully associative LRU directory of CAPACITY (256) glyph outlines keyed by font id and
// glyph index. The directory is empty after reset, with no clearing pass. Every request
// word yields exactly one result word. One request is in flight at a time; the tag memory
// has one read port and is swept in passes of CAPACITY reads each. A lookup that hits or
// stores runs a tag scan, then a rank update sweep. A miss with a failed fetch, or a flush
// that removes nothing, runs the tag scan only. A flush that removes entries runs the scan,
// a prefix pass over the ranks into the shift table, and a renumber sweep. A finished
// result sits in the output register, so the next request is taken while it waits.
`default_nettype none

module glyph_outline_lru_directory (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // font_id[31:0], glyph_index[47:32], fetch_ok[48], zero pad[55:49]
  input  logic [golrd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type[0]
  input  logic [golrd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hit[0], slot[8:1], stored[9], evicted[10], evicted_font[42:11],
  // evicted_glyph[58:43], failed[59], removed_count[68:60], zero pad[71:69]
  output logic [golrd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import golrd_pkg::*;

  req_t req;
  res_t eng_res;
  logic eng_res_valid;
  logic eng_res_ready;
  logic m_tvalid_q;
  res_t m_res_q;

  // Unpack the request word
  assign req.req_type    = req_type_e'(s_axis_tuser[0]);
  assign req.font_id     = s_axis_tdata[FONT_W-1:0];
  assign req.glyph_index = s_axis_tdata[FONT_W+GLYPH_W-1:FONT_W];
  assign req.fetch_ok    = s_axis_tdata[FONT_W+GLYPH_W];

  golrd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res),
    .res_ready_i (eng_res_ready)
  );

  // Advance a result into the output register when it is empty or being taken
  assign eng_res_ready = !m_tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (eng_res_ready) begin
      m_tvalid_q <= eng_res_valid;
    end
  end

  // Hold the result word payload
  always_ff @(posedge clk_i) begin
    if (eng_res_ready && eng_res_valid) begin
      m_res_q <= eng_res;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_res_q};

endmodule

`default_nettype wire
